@@ src/srrip_pkg.sv @@
// Package: types, constants and hash functions for the replacement engine.
`default_nettype none
package srrip_pkg;

    localparam int unsigned NUM_SETS_DEF        = 2048;
    localparam int unsigned NUM_WAYS_DEF        = 16;
    localparam int unsigned OUTCOME_ENTRIES_DEF = 2048;
    localparam int unsigned STRIDE_W            = 13;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd64;
    localparam logic [5:0]  SIG_MASK  = 6'h3F;
    localparam logic [10:0] SLOT_MASK = 11'h7FF;
    localparam logic [3:0]  TICK_MASK = 4'hF;

    typedef enum logic {
        CMD_VICTIM = 1'b0,
        CMD_UPDATE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic        command;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [63:0] phys_addr;
        logic [63:0] prog_counter;
        logic        was_hit;
    } t_in_item;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       filled;
    } t_out_item;

    // Front-to-back queue entry: classified request
    typedef struct packed {
        t_cmd        cmd;
        logic [10:0] set_idx;
        logic [3:0]  way_idx;
        logic [5:0]  sig;
        logic        was_hit;
        logic        step_ok;
        logic        step_valid;
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_OUT
    } t_back_state;

    function automatic logic [5:0] pc_signature(input logic [63:0] pc);
        logic [63:0] x;
        x = pc ^ (pc >> 6) ^ (pc >> 12);
        return x[5:0] & SIG_MASK;
    endfunction

    function automatic logic [10:0] table_slot_raw(input logic [5:0] sig);
        logic [10:0] s;
        s = {5'd0, sig};
        return (s ^ (s << 3)) & SLOT_MASK;
    endfunction

endpackage
`default_nettype wire

@@ src/srrip_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module srrip_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ src/srrip_front.sv @@
// Front end: accepts requests, tracks per-set stride history, classifies.
`default_nettype none
module srrip_front #(
    parameter int unsigned NUM_SETS = srrip_pkg::NUM_SETS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  srrip_pkg::t_in_item              i_in_data,
    input  wire [srrip_pkg::STRIDE_W-1:0]    i_stride,
    input  wire                              i_clear_busy,
    output logic                             o_req_valid,
    input  wire                              i_req_stall,
    output srrip_pkg::t_req                  o_req
);
    import srrip_pkg::*;
    localparam int unsigned SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    // reciprocal constants for the set index modulo (11-bit dividend)
    localparam int unsigned     SET_SH  = 11 + $clog2(NUM_SETS);
    localparam longint unsigned SET_MUL = ((64'd1 << SET_SH) + NUM_SETS - 1) / NUM_SETS;

    logic [64:0] w_prev_rd;     // {valid, address}
    logic [SW-1:0] r_set;
    logic [SW-1:0] r_clr;
    t_in_item    r_item;
    logic        r_busy;
    logic        r_out_v;
    t_req        r_req;
    logic [63:0] w_delta;
    logic [63:0] w_stride64;
    logic        w_acc;
    logic [SW-1:0] w_set;
    logic        w_pvwe;
    logic        w_pv_we;
    logic [SW-1:0] w_pv_waddr;
    logic [64:0] w_pv_wdata;

    // set index modulo set count by reciprocal multiply
    always_comb begin
        logic [39:0] prod;
        logic [39:0] quo;
        logic [39:0] rem;
        prod  = 40'(i_in_data.set_index) * 40'(SET_MUL);
        quo   = prod >> SET_SH;
        rem   = 40'(i_in_data.set_index) - quo * 40'(NUM_SETS);
        w_set = rem[SW-1:0];
    end

    assign o_in_stall = r_busy || r_out_v || i_clear_busy;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_pvwe     = r_busy && (r_item.command == CMD_UPDATE);

    // clear history entries during the reset pass, else store the address of an update request
    assign w_pv_we    = i_clear_busy || w_pvwe;
    assign w_pv_waddr = i_clear_busy ? r_clr : r_set;
    assign w_pv_wdata = i_clear_busy ? 65'd0 : {1'b1, r_item.phys_addr};

    srrip_ram #(.WIDTH(65), .DEPTH(NUM_SETS)) u_prev (
        .i_clk  (i_clk),
        .i_we   (w_pv_we),
        .i_waddr(w_pv_waddr),
        .i_wdata(w_pv_wdata),
        .i_raddr(w_set),
        .o_rdata(w_prev_rd)
    );

    assign w_stride64 = {{(64-STRIDE_W){1'b0}}, i_stride};
    assign w_delta    = r_item.phys_addr - w_prev_rd[63:0];

    // capture request, then classify when previous address arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_out_v <= 1'b0;
            r_clr   <= '0;
        end else begin
            if (i_clear_busy && r_clr != SW'(NUM_SETS - 1)) begin
                r_clr <= r_clr + SW'(1);
            end
            if (w_acc) begin
                r_busy <= 1'b1;
                r_item <= i_in_data;
                r_set  <= w_set;
            end
            if (r_busy) begin
                r_busy  <= 1'b0;
                r_out_v <= 1'b1;
                r_req.cmd        <= t_cmd'(r_item.command);
                r_req.set_idx    <= 11'(r_set);
                r_req.way_idx    <= r_item.way_index;
                r_req.sig        <= pc_signature(r_item.prog_counter);
                r_req.was_hit    <= r_item.was_hit;
                r_req.step_valid <= w_prev_rd[64];
                r_req.step_ok    <= (w_delta == w_stride64) ||
                                    (w_delta == (64'd0 - w_stride64));
            end
            if (r_out_v && !i_req_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_req_valid = r_out_v;
    assign o_req       = r_req;
endmodule
`default_nettype wire

@@ src/srrip_back.sv @@
// Back end: per-set metadata read-modify-write, victim search, insertion.
`default_nettype none
module srrip_back #(
    parameter int unsigned NUM_SETS        = srrip_pkg::NUM_SETS_DEF,
    parameter int unsigned NUM_WAYS        = srrip_pkg::NUM_WAYS_DEF,
    parameter int unsigned OUTCOME_ENTRIES = srrip_pkg::OUTCOME_ENTRIES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    output logic                 o_req_stall,
    input  srrip_pkg::t_req      i_req,
    output logic                 o_clear_busy,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output srrip_pkg::t_out_item o_out_data
);
    import srrip_pkg::*;
    localparam int unsigned SW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned WW  = $clog2(NUM_WAYS);
    localparam int unsigned OW  = $clog2(OUTCOME_ENTRIES);
    localparam int unsigned RW  = 8 * NUM_WAYS;   // rrpv + sig per way
    localparam int unsigned MW  = RW + 2;         // row plus set stream counter
    localparam int unsigned CD  = (NUM_SETS > OUTCOME_ENTRIES) ? NUM_SETS : OUTCOME_ENTRIES;
    localparam int unsigned CW  = $clog2(CD);
    // reciprocal constants for the table slot modulo (11-bit dividend)
    localparam int unsigned     SLOT_SH  = 11 + $clog2(OUTCOME_ENTRIES);
    localparam longint unsigned SLOT_MUL =
        ((64'd1 << SLOT_SH) + OUTCOME_ENTRIES - 1) / OUTCOME_ENTRIES;

    t_back_state r_state, n_state;
    logic [CW-1:0] r_clr;
    t_req          r_req;
    logic [MW-1:0] w_row_rd;
    logic [MW-1:0] n_row;
    logic          w_row_we;
    logic [SW-1:0] w_row_waddr;
    logic [SW-1:0] w_row_raddr;
    logic [MW-1:0] w_row_wdata;
    logic [3:0]    r_tick;
    logic [1:0]    w_ot_acc_rd, w_ot_vic_rd;
    logic          w_ot_we;
    logic [OW-1:0] w_ot_waddr;
    logic [1:0]    w_ot_wdata;
    logic          w_clr_row, w_clr_slot;
    t_out_item     r_out, r_res, n_out;
    logic          r_out_v;
    logic [SW-1:0] w_set;
    logic [WW-1:0] w_way;

    function automatic logic [OW-1:0] oslot(input logic [5:0] s);
        logic [39:0] raw;
        logic [39:0] quo;
        logic [39:0] rem;
        raw = 40'(table_slot_raw(s));
        quo = (raw * 40'(SLOT_MUL)) >> SLOT_SH;
        rem = raw - quo * 40'(OUTCOME_ENTRIES);
        return rem[OW-1:0];
    endfunction

    assign w_set = SW'(r_req.set_idx);

    // way index modulo way count, as a small constant table
    always_comb begin
        w_way = '0;
        for (int k = 0; k < 16; k++) begin
            if (r_req.way_idx == 4'(k)) w_way = WW'(k % NUM_WAYS);
        end
    end

    // read the incoming set on accept, then hold the captured set
    assign w_row_raddr = (r_state == ST_IDLE) ? SW'(i_req.set_idx) : w_set;

    srrip_ram #(.WIDTH(MW), .DEPTH(NUM_SETS)) u_meta (
        .i_clk  (i_clk),
        .i_we   (w_row_we),
        .i_waddr(w_row_waddr),
        .i_wdata(w_row_wdata),
        .i_raddr(w_row_raddr),
        .o_rdata(w_row_rd)
    );

    // outcome counters: two copies, written alike, one per read address
    logic [OW-1:0] w_slot, w_vslot;
    assign w_slot  = oslot(r_req.sig);
    assign w_vslot = oslot(w_row_rd[8*w_way+2 +: 6]);

    srrip_ram #(.WIDTH(2), .DEPTH(OUTCOME_ENTRIES)) u_otab_acc (
        .i_clk  (i_clk),
        .i_we   (w_ot_we),
        .i_waddr(w_ot_waddr),
        .i_wdata(w_ot_wdata),
        .i_raddr(w_slot),
        .o_rdata(w_ot_acc_rd)
    );

    srrip_ram #(.WIDTH(2), .DEPTH(OUTCOME_ENTRIES)) u_otab_vic (
        .i_clk  (i_clk),
        .i_we   (w_ot_we),
        .i_waddr(w_ot_waddr),
        .i_wdata(w_ot_wdata),
        .i_raddr(w_vslot),
        .o_rdata(w_ot_vic_rd)
    );

    assign o_clear_busy = (r_state == ST_CLEAR);
    assign o_req_stall  = (r_state != ST_IDLE);
    assign w_clr_row    = (r_state == ST_CLEAR) && (32'(r_clr) < NUM_SETS);
    assign w_clr_slot   = (r_state == ST_CLEAR) && (32'(r_clr) < OUTCOME_ENTRIES);
    assign w_row_we     = w_clr_row || (r_state == ST_EXEC);
    assign w_row_waddr  = (r_state == ST_CLEAR) ? SW'(r_clr) : w_set;
    // reset row: rrpv 3, sig 0 per way, stream counter 0
    always_comb begin
        logic [MW-1:0] clr_row;
        clr_row = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            clr_row[8*w +: 8] = 8'b0000_0011;
        end
        w_row_wdata = (r_state == ST_CLEAR) ? clr_row : n_row;
    end

    // compute new row, counters and result
    logic [3:0] n_tick;
    logic       n_ot_we;
    logic [OW-1:0] n_ot_addr;
    logic [1:0] n_ot_val;
    always_comb begin
        logic [1:0] top, rv, sc, acc, dec;
        logic       found;
        n_row     = w_row_rd;
        n_out     = '0;
        n_tick    = r_tick;
        n_ot_we   = 1'b0;
        n_ot_addr = w_slot;
        n_ot_val  = '0;
        top       = '0;
        rv        = '0;
        dec       = '0;
        found     = 1'b0;
        acc       = w_ot_acc_rd;
        sc        = w_row_rd[RW +: 2];
        if (r_req.cmd == CMD_VICTIM) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                rv = w_row_rd[8*w +: 2];
                if (rv > top) top = rv;
            end
            for (int w = 0; w < NUM_WAYS; w++) begin
                rv = w_row_rd[8*w +: 2] + (2'd3 - top);
                n_row[8*w +: 2] = rv;
                if (!found && rv == 2'd3) begin
                    found = 1'b1;
                    n_out.victim_way = 4'(w);
                end
            end
        end else begin
            if (r_req.step_valid) begin
                if (r_req.step_ok) begin
                    if (sc != 2'd3) sc = sc + 2'd1;
                end else if (sc != 2'd0) begin
                    sc = sc - 2'd1;
                end
            end
            n_row[RW +: 2] = sc;
            if (r_req.was_hit) begin
                n_row[8*w_way +: 2] = 2'd0;
                n_ot_we   = 1'b1;
                n_ot_addr = w_slot;
                n_ot_val  = (acc != 2'd3) ? acc + 2'd1 : acc;
            end else begin
                dec       = (w_ot_vic_rd != 2'd0) ? w_ot_vic_rd - 2'd1 : 2'd0;
                n_ot_we   = 1'b1;
                n_ot_addr = w_vslot;
                n_ot_val  = dec;
                // accessor counter as seen after the victim decrement
                if (w_vslot == w_slot) acc = dec;
                if (sc >= 2'd2) begin
                    n_tick = (r_tick + 4'd1) & TICK_MASK;
                    n_row[8*w_way +: 2] = 2'd3;
                    if (r_tick != 4'd0) begin
                        n_row[8*w_way+2 +: 6] = 6'd0;
                    end else begin
                        n_row[8*w_way+2 +: 6] = r_req.sig;
                        n_out.filled = 1'b1;
                    end
                end else begin
                    n_row[8*w_way +: 2] = (acc >= 2'd2) ? 2'd0 : 2'd2;
                    n_row[8*w_way+2 +: 6] = r_req.sig;
                    n_out.filled = 1'b1;
                end
            end
        end
    end

    // counter table write: reset value during clearing, else the update
    assign w_ot_we    = w_clr_slot || ((r_state == ST_EXEC) && n_ot_we);
    assign w_ot_waddr = (r_state == ST_CLEAR) ? OW'(r_clr) : n_ot_addr;
    assign w_ot_wdata = (r_state == ST_CLEAR) ? 2'd1 : n_ot_val;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == CW'(CD - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_req_valid) n_state = ST_READ;
            ST_READ:  n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_OUT;
            ST_OUT:   if (!r_out_v || !i_out_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_tick  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + CW'(1);
            if (r_state == ST_IDLE && i_req_valid) r_req <= i_req;
            if (r_out_v && !i_out_stall) r_out_v <= 1'b0;
            if (r_state == ST_EXEC) begin
                r_tick <= n_tick;
                r_res  <= n_out;
            end
            // hand the result over once the output register is free
            if (r_state == ST_OUT && (!r_out_v || !i_out_stall)) begin
                r_out_v <= 1'b1;
                r_out   <= r_res;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

@@ src/ship_rrip_stream_replacement.sv @@
// Top level: SHiP-lite SRRIP replacement engine with stream bypass.
// Path: the front end registers and classifies each request, then the back end
// reads the set row and counter tables, writes the row back and outputs the result.
// One request in the back end at a time.
// Reset: synchronous; a clearing pass over all set rows and counter table entries
// then runs with requests stalled.
`default_nettype none
module ship_rrip_stream_replacement #(
    parameter int unsigned NUM_SETS        = srrip_pkg::NUM_SETS_DEF,
    parameter int unsigned NUM_WAYS        = srrip_pkg::NUM_WAYS_DEF,
    parameter int unsigned OUTCOME_ENTRIES = srrip_pkg::OUTCOME_ENTRIES_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  srrip_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output srrip_pkg::t_out_item          o_out_data,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [srrip_pkg::STRIDE_W-1:0] i_cfg_data
);
    import srrip_pkg::*;

    logic [STRIDE_W-1:0] r_stride;
    logic   w_req_valid, w_req_stall, w_clear_busy;
    t_req   w_req;

    assign o_cfg_ready = 1'b1;

    // stride register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
        end else if (i_cfg_valid) begin
            r_stride <= i_cfg_data;
        end
    end

    srrip_front #(.NUM_SETS(NUM_SETS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_stride    (r_stride),
        .i_clear_busy(w_clear_busy),
        .o_req_valid (w_req_valid),
        .i_req_stall (w_req_stall),
        .o_req       (w_req)
    );

    srrip_back #(
        .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .OUTCOME_ENTRIES(OUTCOME_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .o_req_stall (w_req_stall),
        .i_req       (w_req),
        .o_clear_busy(w_clear_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

@@ src/srrip_checker.sv @@
// Port-level checker for the replacement engine, bound to the top level.
`default_nettype none
module srrip_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_in_stall,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input srrip_pkg::t_out_item o_out_data
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");
    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");
    // input stalled during reset clearing
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken during clear");
    // no result reports a fill together with a nonzero way
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.filled && o_out_data.victim_way != 4'd0))
        else $error("filled with victim way");
endmodule

bind ship_rrip_stream_replacement srrip_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
`default_nettype wire
